@@ rtl/core/rfid_tag_frame_parser_unit_macros.svh @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - assertion macros
// Shared concurrent assertion forms on clk_i; only the first is off in reset.
// ----------------------------------------------------------------------------
`ifndef RFID_TAG_FRAME_PARSER_UNIT_MACROS_SVH
`define RFID_TAG_FRAME_PARSER_UNIT_MACROS_SVH

// check outside reset
`define RFIDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check on every edge, reset included
`define RFIDP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/rfidp_pkg.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - package
// Widths, register indexes, reset values and the structs passed between stages.
// ----------------------------------------------------------------------------
package rfidp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TAG_W      = 64;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned LANES      = TAG_W / BYTE_W;
  localparam int unsigned LANE_W     = $clog2(LANES);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BYTES = 2'd2;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h03;
  localparam logic [CNT_W-1:0]  SKIP_BYTES_RST = 4'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [CNT_W-1:0]  skip_bytes;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic             emit;
    logic [TAG_W-1:0] tag_id;
  } result_t;

endpackage

@@ rtl/core/rfidp_rx_if.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - receive byte channel
// Valid/ready channel carrying one received reader byte per word.
// ----------------------------------------------------------------------------
interface rfidp_rx_if import rfidp_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);

endinterface

@@ rtl/core/rfidp_tag_if.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - tag result channel
// Valid/ready channel carrying one captured tag identifier per word.
// ----------------------------------------------------------------------------
interface rfidp_tag_if import rfidp_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] tag_id;

  modport source (output valid, output tag_id, input ready);
  modport sink   (input valid, input tag_id, output ready);

endinterface

@@ rtl/core/rfidp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - configuration registers
// Start code, end code and preamble length, written through a plain write port.
// ----------------------------------------------------------------------------
module rfidp_cfg_regs import rfidp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  logic [BYTE_W-1:0] start_code_q;
  logic [BYTE_W-1:0] end_code_q;
  logic [CNT_W-1:0]  skip_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= START_CODE_RST;
      end_code_q   <= END_CODE_RST;
      skip_bytes_q <= SKIP_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_CODE: start_code_q <= cfg_wdata_i[BYTE_W-1:0];
        CFG_END_CODE:   end_code_q   <= cfg_wdata_i[BYTE_W-1:0];
        CFG_SKIP_BYTES: skip_bytes_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.start_code = start_code_q;
  assign cfg_o.end_code   = end_code_q;
  assign cfg_o.skip_bytes = skip_bytes_q;

endmodule

@@ rtl/core/rfidp_in_reg.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - input register
// Capture one received byte word and hold it until the parser consumes it.
// ----------------------------------------------------------------------------
module rfidp_in_reg import rfidp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfidp_rx_if.sink   rx_i,
  input  logic       advance_i,
  output in_word_t   word_o
);

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;

  assign rx_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign word_o.valid   = valid_q;
  assign word_o.rx_byte = byte_q;

endmodule

@@ rtl/core/rfidp_parse.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - frame phase logic
// Track wait/skip/capture/end phases, collect identifier bytes, flag a tag.
// ----------------------------------------------------------------------------
`include "rfid_tag_frame_parser_unit_macros.svh"

module rfidp_parse import rfidp_pkg::*; #(
  parameter int unsigned ID_BYTES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  in_word_t word_i,
  input  logic     advance_i,
  output result_t  res_o
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_SKIP = 2'd1;
  localparam logic [1:0] PH_CAPT = 2'd2;
  localparam logic [1:0] PH_END  = 2'd3;

  localparam logic [CNT_W-1:0] ID_LAST = CNT_W'(ID_BYTES);

  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  skip_cnt_q, skip_cnt_d;
  logic [CNT_W-1:0]  byte_idx_q, byte_idx_d;
  logic [BYTE_W-1:0] lane_q [LANES];
  logic [BYTE_W-1:0] lane_d [LANES];

  logic              fire;
  logic              is_start;
  logic              is_end;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  skip_next;
  logic              capture;
  logic              emit;
  logic [LANE_W-1:0] lane_sel;

  assign fire     = word_i.valid && advance_i;
  assign is_start = word_i.rx_byte == cfg_i.start_code;
  assign is_end   = word_i.rx_byte == cfg_i.end_code;
  assign limit    = (cfg_i.skip_bytes == '0) ? CNT_W'(1) : cfg_i.skip_bytes;
  assign skip_next = is_start ? '0 : skip_cnt_q + CNT_W'(1);
  assign lane_sel = byte_idx_q[LANE_W-1:0];

  always_comb begin
    phase_d    = phase_q;
    skip_cnt_d = skip_cnt_q;
    byte_idx_d = byte_idx_q;
    capture    = 1'b0;
    emit       = 1'b0;
    if (fire) begin
      unique case (phase_q)
        PH_WAIT: begin
          skip_cnt_d = '0;
          if (is_start) begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_cnt_d = skip_next;
          if (skip_next != '0 && skip_next >= limit) begin
            phase_d    = PH_CAPT;
            byte_idx_d = '0;
          end
        end
        PH_CAPT: begin
          if (is_start) begin
            phase_d    = PH_SKIP;
            skip_cnt_d = '0;
          end else if (is_end) begin
            phase_d = PH_WAIT;
          end else begin
            capture    = 1'b1;
            byte_idx_d = byte_idx_q + CNT_W'(1);
            if (byte_idx_d >= ID_LAST) begin
              phase_d = PH_END;
            end
          end
        end
        PH_END: begin
          if (is_end) begin
            phase_d = PH_WAIT;
            emit    = 1'b1;
          end else if (is_start) begin
            phase_d    = PH_SKIP;
            skip_cnt_d = '0;
          end
        end
        default: phase_d = PH_WAIT;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_d[k] = lane_q[k];
      if (capture) begin
        if (lane_sel == LANE_W'(k)) begin
          lane_d[k] = word_i.rx_byte;
        end else if (lane_sel == '0) begin
          lane_d[k] = '0;
        end
      end
    end
  end

  always_comb begin
    res_o.emit = emit;
    for (int k = 0; k < LANES; k++) begin
      res_o.tag_id[TAG_W-1-BYTE_W*k -: BYTE_W] = lane_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      skip_cnt_q <= '0;
      byte_idx_q <= '0;
    end else begin
      phase_q    <= phase_d;
      skip_cnt_q <= skip_cnt_d;
      byte_idx_q <= byte_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      lane_q[k] <= lane_d[k];
    end
  end

  `RFIDP_ASSERT(a_emit_then_wait, res_o.emit |=> phase_q == PH_WAIT, "tag emitted but parser did not return to wait")
  `RFIDP_ASSERT(a_end_full, (phase_q == PH_END) |-> (byte_idx_q == ID_LAST), "end phase reached without a full identifier")
  `RFIDP_ASSERT(a_capt_bound, (phase_q == PH_CAPT) |-> (byte_idx_q < ID_LAST), "capture index ran past the identifier length")
  `RFIDP_ASSERT_ALWAYS(a_idle_no_emit, !fire |-> !res_o.emit, "tag flagged without a consumed byte")

endmodule

@@ rtl/core/rfidp_out_reg.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - result register
// Hold a finished tag word until the sink takes it; free the slot otherwise.
// ----------------------------------------------------------------------------
module rfidp_out_reg import rfidp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  result_t    res_i,
  rfidp_tag_if.source tag_o,
  output logic       advance_o
);

  logic             valid_q;
  logic [TAG_W-1:0] tag_q;

  assign advance_o = !valid_q || tag_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_i.emit) begin
      tag_q <= res_i.tag_id;
    end
  end

  assign tag_o.valid  = valid_q;
  assign tag_o.tag_id = tag_q;

endmodule

@@ rtl/core/rfid_tag_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// RFID tag frame parser - top level
// Parse reader byte frames (start code, preamble, identifier, end code) into
// tag identifier words.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle with no gaps while the result
// register does not stall: a byte is held in an input register, where the
// registered phase update consumes it and, on a closing end code, loads the
// tag into the result register, from which the tag word is presented.
// The result register stalls the input side only while it holds an untaken
// tag, and rx ready follows tag ready combinationally in that case. The first
// identifier byte lands in the top eight bits; with fewer than eight
// identifier bytes the low bytes read zero. Configuration writes take effect
// on the next cycle and belong between bytes.
module rfid_tag_frame_parser_unit import rfidp_pkg::*; #(
  parameter int unsigned ID_BYTES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rfidp_rx_if.sink              rx_i,
  rfidp_tag_if.source           tag_o
);

  cfg_t     cfg;
  in_word_t word;
  result_t  res;
  logic     advance;

  rfidp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rfidp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .word_o    (word)
  );

  rfidp_parse #(
    .ID_BYTES (ID_BYTES)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .word_i    (word),
    .advance_i (advance),
    .res_o     (res)
  );

  rfidp_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_i     (res),
    .tag_o     (tag_o),
    .advance_o (advance)
  );

endmodule

@@ test/rfid_tag_frame_parser_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RFID tag frame parser - unit test
// Feeds reader byte streams (clean frames, aborted frames, restarts and line
// noise) under several code and preamble settings, tracks the frame phases
// alongside the parser and checks every tag word it produces.
// ----------------------------------------------------------------------------
module rfid_tag_frame_parser_unit_test;
  import rfidp_pkg::*;

  localparam int unsigned ID_LEN      = 8;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {PH_WAIT, PH_SKIP, PH_CAPT, PH_END} parse_phase_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rfidp_rx_if  rx_ch ();
  rfidp_tag_if tag_ch ();

  rfid_tag_frame_parser_unit #(
    .ID_BYTES (ID_LEN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_ch.sink),
    .tag_o       (tag_ch.source)
  );

  logic [BYTE_W-1:0] pending_bytes [$];
  logic [TAG_W-1:0]  expected_tags [$];

  logic [BYTE_W-1:0] opening_seq [20] = '{
    8'h03, 8'h02, 8'h02, 8'h00, 8'hFF, 8'h10, 8'h20, 8'h30, 8'h40, 8'h00,
    8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h0D, 8'h0A, 8'h03
  };

  // parser shadow
  logic [BYTE_W-1:0] cfg_start;
  logic [BYTE_W-1:0] cfg_end;
  logic [CNT_W-1:0]  cfg_skip;
  parse_phase_e      phase;
  logic [CNT_W-1:0]  skip_cnt;
  logic [CNT_W-1:0]  id_idx;
  logic [TAG_W-1:0]  tag_acc;

  int unsigned queued_total;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  int unsigned rx_gap;
  int unsigned tag_hold;
  int unsigned stall_req;
  int unsigned stall_seen;
  bit          idle_on;
  bit          rx_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void track_byte(input logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] limit;
    limit = (cfg_skip == 0) ? CNT_W'(1) : cfg_skip;
    case (phase)
      PH_WAIT: begin
        if (b == cfg_start) phase = PH_SKIP;
        skip_cnt = '0;
      end
      PH_SKIP: begin
        if (b == cfg_start) skip_cnt = '0;
        else skip_cnt = skip_cnt + 1'b1;
        if (skip_cnt != 0 && skip_cnt >= limit) begin
          phase  = PH_CAPT;
          id_idx = '0;
        end
      end
      PH_CAPT: begin
        if (b == cfg_start) begin
          phase    = PH_SKIP;
          skip_cnt = '0;
        end else if (b == cfg_end) begin
          phase = PH_WAIT;
        end else begin
          if (id_idx[2:0] == 0) tag_acc = '0;
          tag_acc[TAG_W-1-BYTE_W*id_idx[2:0] -: BYTE_W] = b;
          id_idx = id_idx + 1'b1;
          if (id_idx >= ID_LEN) phase = PH_END;
        end
      end
      default: begin
        if (b == cfg_end) begin
          phase = PH_WAIT;
          expected_tags.push_back(tag_acc);
        end else if (b == cfg_start) begin
          phase    = PH_SKIP;
          skip_cnt = '0;
        end
      end
    endcase
  endfunction

  function automatic void flag_error(input string what, input logic [TAG_W-1:0] want,
                                     input logic [TAG_W-1:0] got);
    err_cnt++;
    if (err_cnt <= 10) $display("tag %s: expected %h, got %h", what, want, got);
  endfunction

  function automatic void put(input logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte(input bit allow_end);
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom);
    while (b == cfg_start || (!allow_end && b == cfg_end));
    return b;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_START_CODE: cfg_start = data[BYTE_W-1:0];
      CFG_END_CODE:   cfg_end   = data[BYTE_W-1:0];
      CFG_SKIP_BYTES: cfg_skip  = data[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (pending_bytes.size() != 0 || rx_ch.valid || expected_tags.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_traffic(input int unsigned n);
    int unsigned stop;
    int unsigned kind;
    int unsigned len;
    stop = queued_total + n;
    len  = (cfg_skip == 0) ? 1 : cfg_skip;
    while (queued_total < stop) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        put(cfg_start);
        if ($urandom_range(0, 5) == 0) begin
          put(plain_byte(1'b1));
          put(cfg_start);
        end
        repeat (len) put(plain_byte(1'b1));
        repeat (ID_LEN) put(plain_byte(1'b0));
        repeat ($urandom_range(0, 2)) put(plain_byte(1'b0));
        put(cfg_end);
      end else if (kind == 7) begin
        // cut the identifier short with a code
        put(cfg_start);
        repeat (len) put(plain_byte(1'b1));
        repeat ($urandom_range(0, ID_LEN - 1)) put(plain_byte(1'b0));
        put($urandom_range(0, 1) ? cfg_end : cfg_start);
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 10)) put(BYTE_W'($urandom));
      end else begin
        // reopen while waiting for the end code
        put(cfg_start);
        repeat (len) put(plain_byte(1'b1));
        repeat (ID_LEN) put(plain_byte(1'b0));
        put(cfg_start);
      end
    end
  endtask

  // byte driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_ch.valid <= 1'b0;
    end else if (!rx_ch.valid || rx_taken) begin
      if (rx_gap != 0) begin
        rx_gap      <= rx_gap - 1;
        rx_ch.valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        rx_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rx_gap      <= $urandom_range(0, 7);
        rx_ch.valid <= 1'b0;
      end else begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= pending_bytes.pop_front();
      end
    end
  end

  // tag receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tag_ch.ready <= 1'b0;
    end else if (stall_seen != stall_req) begin
      stall_seen   <= stall_req;
      tag_hold     <= LONG_HOLD;
      tag_ch.ready <= 1'b0;
    end else if (tag_hold != 0) begin
      tag_hold     <= tag_hold - 1;
      tag_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      tag_hold     <= $urandom_range(0, 7);
      tag_ch.ready <= 1'b0;
    end else begin
      tag_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [TAG_W-1:0] want;
    rx_taken <= rx_ch.valid && rx_ch.ready;
    if (rst_ni) begin
      if (rx_ch.valid && rx_ch.ready) track_byte(rx_ch.rx_byte);
      if (tag_ch.valid && tag_ch.ready) begin
        if (expected_tags.size() == 0) begin
          flag_error("unexpected", '0, tag_ch.tag_id);
        end else begin
          want = expected_tags.pop_front();
          if (want !== tag_ch.tag_id) flag_error("mismatch", want, tag_ch.tag_id);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((rx_ch.valid && rx_ch.ready) || (tag_ch.valid && tag_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    tag_ch.ready  = 1'b0;
    cfg_start     = START_CODE_RST;
    cfg_end       = END_CODE_RST;
    cfg_skip      = SKIP_BYTES_RST;
    phase         = PH_WAIT;
    skip_cnt      = '0;
    id_idx        = '0;
    tag_acc       = '0;
    queued_total  = 0;
    err_cnt       = 0;
    idle_cycles   = 0;
    rx_gap        = 0;
    tag_hold      = 0;
    stall_req     = 0;
    stall_seen    = 0;
    idle_on       = 1'b1;
    rx_taken      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_seq[i]) put(opening_seq[i]);
    queue_traffic(100);
    settle();

    write_reg(CFG_START_CODE, 8'h00);
    write_reg(CFG_END_CODE, 8'hFF);
    write_reg(CFG_SKIP_BYTES, 8'hF1);
    stall_req++;
    queue_traffic(110);
    settle();

    write_reg(CFG_START_CODE, 8'hFF);
    write_reg(CFG_END_CODE, 8'h00);
    write_reg(CFG_SKIP_BYTES, 8'h0F);
    queue_traffic(60);
    settle();
    queue_traffic(60);
    settle();

    write_reg(CFG_START_CODE, 8'h5A);
    write_reg(CFG_END_CODE, 8'h5A);
    write_reg(CFG_SKIP_BYTES, 8'hA0);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    queue_traffic(100);
    settle();

    repeat (2) begin
      write_reg(CFG_START_CODE, CFG_DATA_W'($urandom));
      write_reg(CFG_END_CODE, CFG_DATA_W'($urandom));
      write_reg(CFG_SKIP_BYTES, CFG_DATA_W'($urandom));
      queue_traffic(90);
      settle();
    end

    idle_on = 1'b0;
    write_reg(CFG_START_CODE, 8'h02);
    write_reg(CFG_END_CODE, 8'h03);
    write_reg(CFG_SKIP_BYTES, CFG_DATA_W'($urandom_range(1, 15)));
    queue_traffic(90);
    settle();
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
